### design/efsa_pkg.sv
// shared types and constants of the edge flux scatter-accumulate block
package efsa_pkg;

	localparam int VERTICES = 4096;
	localparam int MAX_DIMS = 3;
	localparam int ENTRIES  = VERTICES * MAX_DIMS;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int VTX_W    = 12;
	localparam int CMP_W    = 2;
	localparam int ONE_Q15  = 32768;

	typedef logic [IDX_W-1:0] idx_t;

	// command codes of the input item
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_EDGE = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_EDGE  = 2'd1,
		OP_READ  = 2'd2,
		OP_READZ = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		idx_t               idx_a;
		idx_t               idx_b;
		logic [VTX_W-1:0]   vertex;
		logic [CMP_W-1:0]   comp;
		logic signed [31:0] field;
		logic signed [31:0] sum;
		logic [15:0]        weight;
		logic signed [31:0] coeff;
	} item_t;

	// entry index of a vertex component
	function automatic idx_t entry_idx(logic [VTX_W-1:0] v, logic [CMP_W-1:0] c);
		entry_idx = idx_t'(v) * idx_t'(MAX_DIMS) + idx_t'(c);
	endfunction

endpackage

### design/efsa_front.sv
// front part: classifies input items and queues them for the back part
module efsa_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [1:0]                    component,
	input  logic [11:0]                   vertex,
	input  logic signed [31:0]            field_in,
	input  logic signed [31:0]            sum_in,
	input  logic [11:0]                   start_vertex,
	input  logic [11:0]                   end_vertex,
	input  logic [15:0]                   weight,
	input  logic signed [31:0]            coeff,
	output logic                          head_valid,
	output efsa_pkg::item_t               head,
	input  logic                          pop
);

	efsa_pkg::item_t q_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	efsa_pkg::item_t cls;
	logic            keep;
	logic            push;
	logic            vtx_ok;
	logic            comp_ok;
	logic            edge_ok;

	// classify the incoming item
	always_comb begin
		vtx_ok  = int'(vertex) < efsa_pkg::VERTICES;
		comp_ok = int'(component) < efsa_pkg::MAX_DIMS;
		edge_ok = comp_ok && int'(start_vertex) < efsa_pkg::VERTICES
			&& int'(end_vertex) < efsa_pkg::VERTICES;
		cls.vertex = vertex;
		cls.comp   = component;
		cls.field  = field_in;
		cls.sum    = sum_in;
		cls.coeff  = coeff;
		cls.weight = (weight > 16'(efsa_pkg::ONE_Q15)) ? 16'(efsa_pkg::ONE_Q15) : weight;
		cls.idx_a  = efsa_pkg::entry_idx(vertex, component);
		cls.idx_b  = efsa_pkg::entry_idx(end_vertex, component);
		cls.op     = efsa_pkg::OP_LOAD;
		keep       = 1'b0;
		case (efsa_pkg::cmd_t'(cmd))
			efsa_pkg::CMD_LOAD: begin
				keep = vtx_ok && comp_ok;
			end
			efsa_pkg::CMD_EDGE: begin
				cls.op    = efsa_pkg::OP_EDGE;
				cls.idx_a = efsa_pkg::entry_idx(start_vertex, component);
				keep      = edge_ok;
			end
			efsa_pkg::CMD_READ: begin
				cls.op = (vtx_ok && comp_ok) ? efsa_pkg::OP_READ : efsa_pkg::OP_READZ;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall && keep;
	assign head_valid = (count_q != 2'd0);
	assign head       = q_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### design/efsa_back.sv
// back part: stores, flux arithmetic and sum read-modify-write sequencer
module efsa_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  head_valid,
	input  efsa_pkg::item_t       head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0]           read_vertex,
	output logic [1:0]            read_component,
	output logic signed [31:0]    sum_out
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_R_DATA = 10'b0000000010,
		ST_E_MA   = 10'b0000000100,
		ST_E_MB   = 10'b0000001000,
		ST_E_INT  = 10'b0000010000,
		ST_E_PROD = 10'b0000100000,
		ST_E_FLUX = 10'b0001000000,
		ST_E_ADDS = 10'b0010000000,
		ST_E_RDE  = 10'b0100000000,
		ST_E_ADDE = 10'b1000000000
	} state_t;

	logic signed [31:0] field_mem [efsa_pkg::ENTRIES];
	logic signed [31:0] sum_mem   [efsa_pkg::ENTRIES];

	state_t             state_q;
	state_t             state_d;
	logic               dbl_q;
	efsa_pkg::item_t    item_q;
	logic signed [31:0] fld_a_q;
	logic signed [31:0] fld_b_q;
	logic signed [31:0] sum_rd_q;
	logic signed [48:0] prod_a_q;
	logic signed [48:0] prod_b_q;
	logic signed [31:0] interp_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] flux_q;
	logic               out_vld_q;
	logic [11:0]        out_vtx_q;
	logic [1:0]         out_comp_q;
	logic signed [31:0] out_sum_q;

	logic               fld_we;
	logic               fld_re;
	logic               sum_we;
	logic               sum_re;
	efsa_pkg::idx_t     sum_waddr;
	efsa_pkg::idx_t     sum_raddr;
	logic signed [31:0] sum_wdata;
	logic               out_free;
	logic signed [49:0] int_sum;
	logic signed [64:0] rnd;
	logic signed [50:0] add_s;
	logic signed [50:0] add_e;

	// saturate to 32 bits
	function automatic logic signed [31:0] sat32(logic signed [50:0] v);
		if (v > 51'sd2147483647) begin
			sat32 = 32'sh7fffffff;
		end else if (v < -51'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	assign out_free = !out_vld_q;

	// arithmetic between registers
	always_comb begin
		int_sum = 50'(prod_a_q) + 50'(prod_b_q) + 50'sd16384;
		rnd     = 65'(prod_q) + (dbl_q ? 65'sd16384 : 65'sd32768);
		add_s   = 51'(sum_rd_q) + 51'(flux_q);
		add_e   = 51'(sum_rd_q) - 51'(flux_q);
	end

	// sequencer control
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		fld_we    = 1'b0;
		fld_re    = 1'b0;
		sum_we    = 1'b0;
		sum_re    = 1'b0;
		sum_waddr = head.idx_a;
		sum_raddr = head.idx_a;
		sum_wdata = head.sum;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head.op)
						efsa_pkg::OP_LOAD: begin
							pop    = 1'b1;
							fld_we = 1'b1;
							sum_we = 1'b1;
						end
						efsa_pkg::OP_EDGE: begin
							pop     = 1'b1;
							fld_re  = 1'b1;
							state_d = ST_E_MA;
						end
						efsa_pkg::OP_READ: begin
							if (out_free) begin
								pop     = 1'b1;
								sum_re  = 1'b1;
								state_d = ST_R_DATA;
							end
						end
						default: begin
							pop = out_free;
						end
					endcase
				end
			end
			ST_R_DATA: state_d = ST_IDLE;
			ST_E_MA:   state_d = ST_E_MB;
			ST_E_MB:   state_d = ST_E_INT;
			ST_E_INT:  state_d = ST_E_PROD;
			ST_E_PROD: state_d = ST_E_FLUX;
			ST_E_FLUX: begin
				sum_re    = 1'b1;
				sum_raddr = item_q.idx_a;
				state_d   = ST_E_ADDS;
			end
			ST_E_ADDS: begin
				sum_we    = 1'b1;
				sum_waddr = item_q.idx_a;
				sum_wdata = sat32(add_s);
				state_d   = ST_E_RDE;
			end
			ST_E_RDE: begin
				sum_re    = 1'b1;
				sum_raddr = item_q.idx_b;
				state_d   = ST_E_ADDE;
			end
			ST_E_ADDE: begin
				sum_we    = 1'b1;
				sum_waddr = item_q.idx_b;
				sum_wdata = sat32(add_e);
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// field store, two read ports
	always_ff @(posedge clk) begin
		if (fld_we) begin
			field_mem[head.idx_a] <= head.field;
		end
		if (fld_re) begin
			fld_a_q <= field_mem[head.idx_a];
			fld_b_q <= field_mem[head.idx_b];
		end
	end

	// sum store, one read and one write port
	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_raddr];
		end
	end

	// flux datapath
	always_ff @(posedge clk) begin
		if (pop) item_q <= head;
		if (state_q == ST_E_MA) begin
			prod_a_q <= 49'(fld_a_q) * 49'($signed({1'b0, item_q.weight}));
		end
		if (state_q == ST_E_MB) begin
			prod_b_q <= 49'(fld_b_q)
				* 49'($signed(17'(efsa_pkg::ONE_Q15) - {1'b0, item_q.weight}));
		end
		if (state_q == ST_E_INT) interp_q <= int_sum[46:15];
		if (state_q == ST_E_PROD) prod_q <= 64'(interp_q) * 64'(item_q.coeff);
		if (state_q == ST_E_FLUX) flux_q <= dbl_q ? rnd[64:15] : {rnd[64], rnd[64:16]};
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_R_DATA) begin
			out_vtx_q  <= item_q.vertex;
			out_comp_q <= item_q.comp;
			out_sum_q  <= sum_rd_q;
		end else if (pop && head.op == efsa_pkg::OP_READZ) begin
			out_vtx_q  <= head.vertex;
			out_comp_q <= head.comp;
			out_sum_q  <= '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dbl_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) dbl_q <= cfg_wr_data;
			if (state_q == ST_R_DATA || (pop && head.op == efsa_pkg::OP_READZ)) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign read_vertex    = out_vtx_q;
	assign read_component = out_comp_q;
	assign sum_out        = out_sum_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE) else $error("queue popped while busy");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_R_DATA
			|| ($past(pop) && $past(head.op) == efsa_pkg::OP_READZ))
		else $error("result without a read item");

	a_read_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R_DATA) |-> !out_vld_q) else $error("result register overrun");

endmodule

### design/edge_flux_scatter_accumulate.sv
// top level of the edge flux scatter-accumulate block
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | cmd component vertex field_in sum_in
//           |                        | start_vertex end_vertex weight coeff
//  output   | out_valid / out_stall  | read_vertex read_component sum_out
//  config   | cfg_wr_en              | cfg_wr_data (double_flux)
//
// a two-entry queue takes items while the back part works; dropped items are never queued
// load: written to both stores when popped; read: waits for a free result register,
// then its sum store read is registered there; edge: the two interpolation multiplies,
// the coefficient product and the sum store read-modify-write of both vertices
// reset clears control only; store entries are undefined until loaded
// out_stall holds the result register and backs up the queue, then in_stall
module edge_flux_scatter_accumulate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [1:0]         component,
	input  logic [11:0]        vertex,
	input  logic signed [31:0] field_in,
	input  logic signed [31:0] sum_in,
	input  logic [11:0]        start_vertex,
	input  logic [11:0]        end_vertex,
	input  logic [15:0]        weight,
	input  logic signed [31:0] coeff,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        read_vertex,
	output logic [1:0]         read_component,
	output logic signed [31:0] sum_out
);

	logic            head_valid;
	efsa_pkg::item_t head;
	logic            pop;

	// classify and queue
	efsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.component    (component),
		.vertex       (vertex),
		.field_in     (field_in),
		.sum_in       (sum_in),
		.start_vertex (start_vertex),
		.end_vertex   (end_vertex),
		.weight       (weight),
		.coeff        (coeff),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	// execute
	efsa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_vertex    (read_vertex),
		.read_component (read_component),
		.sum_out        (sum_out)
	);

endmodule

### test/tb.sv
// testbench of the edge flux scatter-accumulate block
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic cfg_wr_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] cmd = 0;
	logic [1:0] component = 0;
	logic [11:0] vertex = 0;
	logic signed [31:0] field_in = 0;
	logic signed [31:0] sum_in = 0;
	logic [11:0] start_vertex = 0;
	logic [11:0] end_vertex = 0;
	logic [15:0] weight = 0;
	logic signed [31:0] coeff = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [11:0] read_vertex;
	logic [1:0] read_component;
	logic signed [31:0] sum_out;

	edge_flux_scatter_accumulate dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .component(component),
		.vertex(vertex), .field_in(field_in), .sum_in(sum_in),
		.start_vertex(start_vertex), .end_vertex(end_vertex), .weight(weight),
		.coeff(coeff), .out_valid(out_valid), .out_stall(out_stall),
		.read_vertex(read_vertex), .read_component(read_component), .sum_out(sum_out)
	);

	// expected read result
	typedef struct packed {
		logic [11:0]        vtx;
		logic [1:0]         comp;
		logic signed [31:0] sum;
	} sum_read_t;

	// predictor state
	logic signed [31:0] field_mem [efsa_pkg::ENTRIES];
	logic signed [31:0] sum_mem [efsa_pkg::ENTRIES];
	bit dbl_mode = 0;
	sum_read_t pending_reads[$];

	int errors = 0;
	int cycles = 0;
	int reads_seen = 0;
	int edges_sent = 0;
	int sats = 0;

	always #4 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// receiver stall pattern, bursts mostly short and a few long
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n || stall_mode == 0) begin
			out_stall <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < (stall_mode == 2 ? 60 : 30));
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
		end
	end

	// result checker
	always @(posedge clk) begin
		sum_read_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				report("unexpected result", sum_out, 32'd0);
			end else begin
				w = pending_reads.pop_front();
				reads_seen++;
				if (read_vertex !== w.vtx)
					report("read_vertex", 32'(read_vertex), 32'(w.vtx));
				if (read_component !== w.comp)
					report("read_component", 32'(read_component), 32'(w.comp));
				if (sum_out !== w.sum) report("sum_out", sum_out, w.sum);
			end
		end
	end

	function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sh7FFFFFFF) begin
			sats++;
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sh80000000) begin
			sats++;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// predictor: apply one accepted item
	task automatic predict(efsa_pkg::cmd_t c, logic [1:0] cp, logic [11:0] v,
			logic signed [31:0] f, logic signed [31:0] s, logic [11:0] sv,
			logic [11:0] ev, logic [15:0] wt, logic signed [31:0] k);
		int ia, ib;
		logic signed [63:0] ww, ip, pr, fl;
		sum_read_t r;
		ia = int'(sv) * efsa_pkg::MAX_DIMS + int'(cp);
		ib = int'(ev) * efsa_pkg::MAX_DIMS + int'(cp);
		case (c)
			efsa_pkg::CMD_LOAD: begin
				if (cp < efsa_pkg::MAX_DIMS) begin
					ia = int'(v) * efsa_pkg::MAX_DIMS + int'(cp);
					field_mem[ia] = f;
					sum_mem[ia] = s;
				end
			end
			efsa_pkg::CMD_EDGE: begin
				if (cp < efsa_pkg::MAX_DIMS) begin
					ww = (wt > efsa_pkg::ONE_Q15) ? 64'(efsa_pkg::ONE_Q15) : 64'(wt);
					ip = rnd_shift(ww * field_mem[ia]
						+ (efsa_pkg::ONE_Q15 - ww) * field_mem[ib], 15);
					pr = ip * k;
					fl = rnd_shift(pr, dbl_mode ? 15 : 16);
					sum_mem[ia] = clamp32(sum_mem[ia] + fl);
					sum_mem[ib] = clamp32(sum_mem[ib] - fl);
					edges_sent++;
				end
			end
			efsa_pkg::CMD_READ: begin
				r.vtx = v;
				r.comp = cp;
				r.sum = (cp < efsa_pkg::MAX_DIMS)
					? sum_mem[int'(v) * efsa_pkg::MAX_DIMS + int'(cp)] : 32'sd0;
				pending_reads.push_back(r);
			end
			default: ;
		endcase
	endtask

	// send one item, sometimes with a random gap before it while gap_mode is set
	int gap_mode = 1;
	task automatic send_item(efsa_pkg::cmd_t c, logic [1:0] cp, logic [11:0] v,
			logic signed [31:0] f, logic signed [31:0] s, logic [11:0] sv,
			logic [11:0] ev, logic [15:0] wt, logic signed [31:0] k);
		int g;
		g = 0;
		if (gap_mode != 0 && $urandom_range(0, 2) == 0)
			g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		cmd <= c;
		component <= cp;
		vertex <= v;
		field_in <= f;
		sum_in <= s;
		start_vertex <= sv;
		end_vertex <= ev;
		weight <= wt;
		coeff <= k;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict(c, cp, v, f, s, sv, ev, wt, k);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 0;
		dbl_mode = m;
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 65536 * 4) - 65536 * 2;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rnd_weight();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'(efsa_pkg::ONE_Q15);
			2: return 16'($urandom_range(efsa_pkg::ONE_Q15 + 1, 65535));
			default: return 16'($urandom_range(0, efsa_pkg::ONE_Q15));
		endcase
	endfunction

	// corner values through a small vertex set
	task automatic test_directed();
		send_item(efsa_pkg::CMD_LOAD, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFF00, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_LOAD, 0, 4095, 32'sh80000000, 32'sh80000100, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_LOAD, 2, 4095, 32'sh00010000, 32'sh0, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_LOAD, 2, 7, -32'sh00018000, 32'sh10, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_LOAD, 3, 9, 32'sh1234, 32'sh5678, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_EDGE, 0, 0, 0, 0, 0, 4095, 16'd0, 32'sh7FFFFFFF);
		send_item(efsa_pkg::CMD_EDGE, 0, 0, 0, 0, 0, 4095, 16'd32768, 32'sh80000000);
		send_item(efsa_pkg::CMD_EDGE, 2, 0, 0, 0, 4095, 7, 16'hFFFF, -32'sh00008000);
		send_item(efsa_pkg::CMD_EDGE, 2, 0, 0, 0, 7, 7, 16'd16384, 32'sh00020000);
		send_item(efsa_pkg::CMD_EDGE, 3, 0, 0, 0, 1, 2, 16'd100, 32'sh1);
		send_item(efsa_pkg::CMD_NONE, 1, 5, 32'shFFFFFFFF, 32'shFFFFFFFF, 12'hFFF, 12'hFFF,
			16'hFFFF, 32'shFFFFFFFF);
		send_item(efsa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_READ, 0, 4095, 0, 0, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_READ, 2, 4095, 0, 0, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_READ, 2, 7, 0, 0, 0, 0, 0, 0);
		send_item(efsa_pkg::CMD_READ, 3, 12'hABC, 0, 0, 0, 0, 0, 0);
	endtask

	// random traffic, mostly well-formed, on a small pool of loaded entries
	task automatic test_random(int n);
		int vtx_pool [16];
		int p, cp, sv, ev;
		for (int i = 0; i < 16; i++) vtx_pool[i] = (i < 2) ? (i * 4095) : $urandom_range(0, 4095);
		for (int i = 0; i < 16; i++)
			for (int c = 0; c < efsa_pkg::MAX_DIMS; c++)
				send_item(efsa_pkg::CMD_LOAD, 2'(c), 12'(vtx_pool[i]), rnd_val(), rnd_val(),
					0, 0, 0, 0);
		for (int i = 0; i < n; i++) begin
			cp = $urandom_range(0, 2);
			sv = vtx_pool[$urandom_range(0, 15)];
			ev = ($urandom_range(0, 9) == 0) ? sv : vtx_pool[$urandom_range(0, 15)];
			p = $urandom_range(0, 99);
			if (p < 10)
				send_item(efsa_pkg::CMD_LOAD, 2'(cp), 12'(sv), rnd_val(), rnd_val(),
					12'($urandom), 12'($urandom), 16'($urandom), $urandom);
			else if (p < 60)
				send_item(efsa_pkg::CMD_EDGE, 2'(cp), 12'($urandom), $urandom, $urandom,
					12'(sv), 12'(ev), rnd_weight(), rnd_val());
			else if (p < 90)
				send_item(efsa_pkg::CMD_READ, 2'(cp), 12'(sv), $urandom, $urandom,
					12'($urandom), 12'($urandom), 16'($urandom), $urandom);
			else if (p < 95)
				send_item(efsa_pkg::CMD_READ, 3, 12'($urandom), 0, 0, 0, 0, 0, 0);
			else
				send_item(p < 98 ? efsa_pkg::CMD_EDGE : efsa_pkg::CMD_NONE, 3, 12'($urandom),
					$urandom, $urandom, 12'($urandom), 12'($urandom), 16'($urandom),
					$urandom);
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		write_mode(1);
		test_directed();
		write_mode(0);
		stall_mode = 1;
		test_random(450);
		write_mode(1);
		stall_mode = 2;
		test_random(450);
		write_mode(0);
		stall_mode = 0;
		gap_mode = 0;
		test_random(300);
		drain();
		$display("covered %0d edges, %0d reads checked, %0d saturations in both flux modes",
			edges_sent, reads_seen, sats);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
